FILE: hdl/probabilistic_step_sequencer_core_defines.svh
// Assertion macros for the checker of the step sequencer.
`ifndef PROBABILISTIC_STEP_SEQUENCER_CORE_DEFINES_SVH
`define PROBABILISTIC_STEP_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

  // Store geometry.
  localparam int NUM_PATTERNS = 8;
  localparam int MAX_STEPS    = 64;
  localparam int DEPTH        = NUM_PATTERNS * MAX_STEPS;
  localparam int PAT_W        = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int STEP_W       = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int ADDR_W       = $clog2(DEPTH);

  // Field widths.
  localparam int POS_W    = 40;
  localparam int FRAC_W   = 16;
  localparam int RES_W    = 2;
  localparam int MAX_RES  = 3;
  localparam int SHIFT_W  = POS_W + MAX_RES;
  localparam int WHOLE_W  = SHIFT_W - FRAC_W;
  localparam int LEN_W    = 7;
  localparam int SLOT_W   = 3;
  localparam int SNUM_W   = 6;
  localparam int EV_W     = 4;
  localparam int PROB_W   = 17;
  localparam int INT_W    = 16;
  localparam int SEED_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CIDX_W   = 3;

  // Register reset values.
  localparam logic [RES_W-1:0] RESET_RES  = RES_W'(2);
  localparam logic [LEN_W-1:0] RESET_LEN  = LEN_W'(16);
  localparam logic [SEED_W-1:0] RESET_SEED = SEED_W'(1);

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_RESOLUTION = 3'd1,
    REG_LENGTH     = 3'd2,
    REG_PATTERN    = 3'd3,
    REG_SEED       = 3'd4
  } reg_e;

  // One step of a pattern as it sits in the store.
  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [PROB_W-1:0] prob;
    logic [INT_W-1:0]  inten;
  } step_t;

  function automatic logic [PAT_W-1:0] sat_pat(logic [SLOT_W-1:0] s);
    return (int'(s) >= NUM_PATTERNS) ? PAT_W'(NUM_PATTERNS - 1) : PAT_W'(s);
  endfunction

  function automatic logic [STEP_W-1:0] sat_step(logic [SNUM_W-1:0] s);
    return (int'(s) >= MAX_STEPS) ? STEP_W'(MAX_STEPS - 1) : STEP_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [PAT_W-1:0] p,
                                                  logic [STEP_W-1:0] s);
    return ADDR_W'(p) * ADDR_W'(MAX_STEPS) + ADDR_W'(s);
  endfunction

endpackage

FILE: hdl/pss_mod.sv
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module pss_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pss_pkg::WHOLE_W-1:0]   dividend_i,
  input  logic [pss_pkg::LEN_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [pss_pkg::LEN_W-1:0]     rem_o
);

  localparam int CNT_W = $clog2(pss_pkg::WHOLE_W);

  logic                         busy_q;
  logic                         done_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [pss_pkg::WHOLE_W-1:0]  dvd_q;
  logic [pss_pkg::LEN_W-1:0]    div_q;
  logic [pss_pkg::LEN_W-1:0]    rem_q;
  logic [pss_pkg::LEN_W:0]      trial;
  logic [pss_pkg::LEN_W:0]      diff;

  // Bring down the next dividend bit and subtract where it fits.
  assign trial = {rem_q, dvd_q[pss_pkg::WHOLE_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(pss_pkg::WHOLE_W - 1);
        dvd_q  <= dividend_i;
        div_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= dvd_q << 1;
        if (trial >= {1'b0, div_q}) begin
          rem_q <= diff[pss_pkg::LEN_W-1:0];
        end else begin
          rem_q <= trial[pss_pkg::LEN_W-1:0];
        end
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/probabilistic_step_sequencer_core.sv
`timescale 1ns / 1ps

// Channel | Handshake              | Beat contents
// in      | in_valid_i, in_stall_o | operation, position, tempo, slot, step fields
// out     | out_valid_o, out_stall_i | triggered, event_code, intensity, probability
// cfg     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// An advance beat waits on the 27-step remainder unit, then reads the store; a
// repeat of the last step skips the read. Stopped, disabled or empty advances and
// restarts go straight to the result, writes via S_WRITE, reads via S_RADDR, S_USE.
// One beat is worked on at a time; the next is taken while a result waits.
// After reset a clearing pass sweeps all 512 entries of the step store, one entry a
// cycle, with in_stall_o held high. A stalled output holds its beat.
module probabilistic_step_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [pss_pkg::POS_W-1:0]     position_i,
  input  logic [15:0]                   tempo_i,
  input  logic [pss_pkg::SLOT_W-1:0]    slot_i,
  input  logic [pss_pkg::SNUM_W-1:0]    step_number_i,
  input  logic [pss_pkg::EV_W-1:0]      step_event_i,
  input  logic [pss_pkg::PROB_W-1:0]    step_probability_i,
  input  logic [pss_pkg::INT_W-1:0]     step_intensity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          triggered_o,
  output logic [pss_pkg::EV_W-1:0]      event_code_o,
  output logic [pss_pkg::INT_W-1:0]     intensity_o,
  output logic [pss_pkg::PROB_W-1:0]    probability_o,
  input  logic                          cfg_we_i,
  input  logic [pss_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [pss_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RADDR,
    S_USE,
    S_WRITE,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [pss_pkg::ADDR_W-1:0]    clr_q;
  pss_pkg::op_e                  op_q;
  logic [pss_pkg::ADDR_W-1:0]    addr_q;
  pss_pkg::step_t                wdata_q;
  pss_pkg::step_t                rd_data_q;
  logic                          last_valid_q;
  logic [pss_pkg::LEN_W-1:0]     last_q;
  logic [pss_pkg::SEED_W-1:0]    random_q;

  logic                          cfg_en_q;
  logic [pss_pkg::RES_W-1:0]     cfg_res_q;
  logic [pss_pkg::LEN_W-1:0]     cfg_len_q;
  logic [pss_pkg::SLOT_W-1:0]    cfg_pat_q;

  logic                          res_trig_q;
  logic [pss_pkg::EV_W-1:0]      res_ev_q;
  logic [pss_pkg::INT_W-1:0]     res_int_q;
  logic [pss_pkg::PROB_W-1:0]    res_prob_q;

  logic                          out_valid_q;
  logic                          out_trig_q;
  logic [pss_pkg::EV_W-1:0]      out_ev_q;
  logic [pss_pkg::INT_W-1:0]     out_int_q;
  logic [pss_pkg::PROB_W-1:0]    out_prob_q;

  pss_pkg::step_t                mem_q [pss_pkg::DEPTH];
  logic                          mem_we;
  logic [pss_pkg::ADDR_W-1:0]    mem_wa;
  pss_pkg::step_t                mem_wd;

  logic                          in_acc;
  pss_pkg::op_e                  in_op;
  logic [pss_pkg::LEN_W-1:0]     len;
  logic                          gate;
  logic [pss_pkg::SHIFT_W-1:0]   shifted;
  logic                          div_start;
  logic                          div_done;
  logic [pss_pkg::LEN_W-1:0]     div_rem;
  logic [pss_pkg::SEED_W-1:0]    xs_a;
  logic [pss_pkg::SEED_W-1:0]    xs_b;
  logic [pss_pkg::SEED_W-1:0]    xs_next;
  logic                          needs_draw;
  logic                          fire;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_op      = pss_pkg::op_e'(operation_i);

  // Pattern length in use, clamped to the store's row size.
  assign len  = (int'(cfg_len_q) > pss_pkg::MAX_STEPS) ?
                pss_pkg::LEN_W'(pss_pkg::MAX_STEPS) : cfg_len_q;
  assign gate = cfg_en_q && (tempo_i != '0) && (len != '0);

  // Whole steps: position scaled by the resolution, fraction dropped.
  assign shifted   = {{pss_pkg::MAX_RES{1'b0}}, position_i} << cfg_res_q;
  assign div_start = in_acc && (in_op == pss_pkg::OP_ADVANCE) && gate;

  pss_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (shifted[pss_pkg::SHIFT_W-1:pss_pkg::FRAC_W]),
    .divisor_i  (len),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Next xorshift32 value and the probability test.
  assign xs_a       = random_q ^ (random_q << 13);
  assign xs_b       = xs_a ^ (xs_a >> 17);
  assign xs_next    = xs_b ^ (xs_b << 5);
  assign needs_draw = (rd_data_q.ev != '0) && !rd_data_q.prob[pss_pkg::PROB_W-1];
  assign fire       = (rd_data_q.ev != '0) &&
                      (rd_data_q.prob[pss_pkg::PROB_W-1] ||
                       ({1'b0, xs_next[31:16]} <= rd_data_q.prob));

  // Store write port: clearing sweep or a write beat.
  assign mem_we = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign mem_wa = (state_q == S_CLEAR) ? clr_q : addr_q;
  assign mem_wd = (state_q == S_CLEAR) ? '0 : wdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[addr_q];
  end

  // Sequencer, configuration registers and output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      op_q         <= pss_pkg::OP_ADVANCE;
      addr_q       <= '0;
      wdata_q      <= '0;
      last_valid_q <= 1'b0;
      last_q       <= '0;
      random_q     <= pss_pkg::RESET_SEED;
      cfg_en_q     <= 1'b0;
      cfg_res_q    <= pss_pkg::RESET_RES;
      cfg_len_q    <= pss_pkg::RESET_LEN;
      cfg_pat_q    <= '0;
      res_trig_q   <= 1'b0;
      res_ev_q     <= '0;
      res_int_q    <= '0;
      res_prob_q   <= '0;
      out_valid_q  <= 1'b0;
      out_trig_q   <= 1'b0;
      out_ev_q     <= '0;
      out_int_q    <= '0;
      out_prob_q   <= '0;
    end else begin
      // A taken result beat leaves the output register unless a new one replaces it.
      if (!out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == pss_pkg::ADDR_W'(pss_pkg::DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            op_q       <= in_op;
            addr_q     <= pss_pkg::make_addr(pss_pkg::sat_pat(slot_i),
                                             pss_pkg::sat_step(step_number_i));
            wdata_q    <= '{ev: step_event_i, prob: step_probability_i,
                            inten: step_intensity_i};
            res_trig_q <= 1'b0;
            res_ev_q   <= '0;
            res_int_q  <= '0;
            res_prob_q <= '0;
            unique case (in_op)
              pss_pkg::OP_ADVANCE: state_q <= gate ? S_DIV : S_DONE;
              pss_pkg::OP_WRITE:   state_q <= S_WRITE;
              pss_pkg::OP_READ:    state_q <= S_RADDR;
              pss_pkg::OP_RESTART: begin
                last_valid_q <= 1'b0;
                last_q       <= '0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end

        // Wait for the step index; a repeat of the last step gives a quiet result.
        S_DIV: begin
          if (div_done) begin
            if (last_valid_q && (div_rem == last_q)) begin
              state_q <= S_DONE;
            end else begin
              last_valid_q <= 1'b1;
              last_q       <= div_rem;
              addr_q       <= pss_pkg::make_addr(pss_pkg::sat_pat(cfg_pat_q),
                                                 pss_pkg::STEP_W'(div_rem));
              state_q      <= S_RADDR;
            end
          end
        end

        S_RADDR: begin
          state_q <= S_USE;
        end

        S_USE: begin
          if (op_q == pss_pkg::OP_READ) begin
            res_ev_q   <= rd_data_q.ev;
            res_int_q  <= rd_data_q.inten;
            res_prob_q <= rd_data_q.prob;
          end else begin
            if (needs_draw) begin
              random_q <= xs_next;
            end
            if (fire) begin
              res_trig_q <= 1'b1;
              res_ev_q   <= rd_data_q.ev;
              res_int_q  <= rd_data_q.inten;
            end
          end
          state_q <= S_DONE;
        end

        S_WRITE: begin
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_trig_q  <= res_trig_q;
            out_ev_q    <= res_ev_q;
            out_int_q   <= res_int_q;
            out_prob_q  <= res_prob_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // Configuration writes; a seed of zero loads one.
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pss_pkg::REG_ENABLED:    cfg_en_q  <= cfg_data_i[0];
          pss_pkg::REG_RESOLUTION: cfg_res_q <= cfg_data_i[pss_pkg::RES_W-1:0];
          pss_pkg::REG_LENGTH:     cfg_len_q <= cfg_data_i[pss_pkg::LEN_W-1:0];
          pss_pkg::REG_PATTERN:    cfg_pat_q <= cfg_data_i[pss_pkg::SLOT_W-1:0];
          pss_pkg::REG_SEED: begin
            random_q <= (cfg_data_i[pss_pkg::SEED_W-1:0] == '0) ?
                        pss_pkg::RESET_SEED : cfg_data_i[pss_pkg::SEED_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign triggered_o   = out_trig_q;
  assign event_code_o  = out_ev_q;
  assign intensity_o   = out_int_q;
  assign probability_o = out_prob_q;

endmodule

FILE: hdl/pss_checker.sv
`timescale 1ns / 1ps
`include "probabilistic_step_sequencer_core_defines.svh"

// Port-level checks on the step sequencer.
module pss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        triggered_o,
  input logic [pss_pkg::EV_W-1:0]    event_code_o,
  input logic [pss_pkg::INT_W-1:0]   intensity_o,
  input logic [pss_pkg::PROB_W-1:0]  probability_o
);

  // A stalled result beat stays and keeps its contents.
  `PSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(triggered_o) && $stable(event_code_o) &&
                  $stable(intensity_o) && $stable(probability_o),
                  "stalled result beat changed")

  // A fired step always carries an event.
  `PSS_ASSERT_IMP(a_trig_event, clk_i, rst_ni, out_valid_o && triggered_o,
                  event_code_o != '0, "trigger without event code")

  // Probability is only reported by read beats, which never trigger.
  `PSS_ASSERT_IMP(a_trig_prob, clk_i, rst_ni, out_valid_o && triggered_o,
                  probability_o == '0, "trigger with probability")

  // The store is being cleared straight after reset, so no beat is taken.
  `PSS_ASSERT_IMP(a_clear_stall, clk_i, rst_ni, $rose(rst_ni), in_stall_o,
                  "input open during clearing")

endmodule

bind probabilistic_step_sequencer_core pss_checker u_pss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .triggered_o   (triggered_o),
  .event_code_o  (event_code_o),
  .intensity_o   (intensity_o),
  .probability_o (probability_o)
);

FILE: verif/tb_probabilistic_step_sequencer_core.sv
`timescale 1ns / 1ps

module tb_probabilistic_step_sequencer_core;
  import pss_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 125;
  localparam int DRAIN_LIMIT = 100000;

  // One input beat as the sender offers it.
  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  pos;
    logic [15:0]       tempo;
    logic [SLOT_W-1:0] slot;
    logic [SNUM_W-1:0] stepn;
    logic [EV_W-1:0]   ev;
    logic [PROB_W-1:0] prob;
    logic [INT_W-1:0]  inten;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic              fired;
    logic [EV_W-1:0]   ev;
    logic [INT_W-1:0]  inten;
    logic [PROB_W-1:0] prob;
  } outcome_t;

  // A row of the directed table: either a register write or a beat.
  typedef struct {
    bit                is_reg;
    reg_e              idx;
    logic [CFG_W-1:0]  val;
    beat_t             beat;
    bit                known;
    outcome_t          want;
  } row_t;

  localparam outcome_t QUIET = '0;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                out_stall_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i  = '0;
  beat_t               cur_beat    = '0;
  bit                  cur_known   = 1'b0;
  outcome_t            cur_want    = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                triggered_o;
  logic [EV_W-1:0]     event_code_o;
  logic [INT_W-1:0]    intensity_o;
  logic [PROB_W-1:0]   probability_o;

  // Predictor state: step store, last step seen, generator and registers.
  step_t               pattern_mem [DEPTH];
  bit                  have_last;
  int unsigned         last_idx;
  logic [SEED_W-1:0]   rng;
  logic                reg_enabled;
  logic [RES_W-1:0]    reg_res;
  logic [LEN_W-1:0]    reg_length;
  logic [SLOT_W-1:0]   reg_pattern;

  outcome_t            outcomes_due [$];
  row_t                stim_table [$];
  logic [POS_W-1:0]    play_pos;
  bit                  hold_off_req = 1'b0;
  int                  mismatches   = 0;
  int                  fired_count  = 0;
  int                  read_count   = 0;
  int                  write_count  = 0;
  int                  restart_count = 0;
  int                  beat_count   = 0;
  int                  reg_writes   = 0;

  probabilistic_step_sequencer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (cur_beat.op),
    .position_i         (cur_beat.pos),
    .tempo_i            (cur_beat.tempo),
    .slot_i             (cur_beat.slot),
    .step_number_i      (cur_beat.stepn),
    .step_event_i       (cur_beat.ev),
    .step_probability_i (cur_beat.prob),
    .step_intensity_i   (cur_beat.inten),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .triggered_o        (triggered_o),
    .event_code_o       (event_code_o),
    .intensity_o        (intensity_o),
    .probability_o      (probability_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Store address with slot and step clamped to the store geometry.
  function automatic int unsigned store_index(logic [SLOT_W-1:0] s, logic [SNUM_W-1:0] n);
    int unsigned p;
    int unsigned k;
    p = (int'(s) >= NUM_PATTERNS) ? NUM_PATTERNS - 1 : int'(s);
    k = (int'(n) >= MAX_STEPS) ? MAX_STEPS - 1 : int'(n);
    return p * MAX_STEPS + k;
  endfunction

  // xorshift32; the draw is the top half of the new state.
  function automatic logic [15:0] xorshift_next();
    logic [31:0] x;
    x = rng;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng = x;
    return x[31:16];
  endfunction

  // Works out the result of one accepted beat and updates the predictor state.
  function automatic outcome_t step_outcome(beat_t b);
    outcome_t    o;
    int unsigned len;
    int unsigned cur;
    logic [63:0] whole;
    step_t       c;
    bit          fire;
    o = '0;
    case (b.op)
      OP_ADVANCE: begin
        len = (int'(reg_length) > MAX_STEPS) ? MAX_STEPS : int'(reg_length);
        if (reg_enabled && b.tempo != 0 && len != 0) begin
          whole = (64'(b.pos) << reg_res) >> FRAC_W;
          cur = 32'(whole % 64'(len));
          if (!(have_last && cur == last_idx)) begin
            have_last = 1'b1;
            last_idx  = cur;
            c = pattern_mem[store_index(reg_pattern, SNUM_W'(cur))];
            if (c.ev != 0) begin
              fire = 1'b1;
              // Full probability (or more) fires without a draw.
              if (c.prob < 17'h10000) fire = ({1'b0, xorshift_next()} <= c.prob);
              if (fire) begin
                o.fired = 1'b1;
                o.ev    = c.ev;
                o.inten = c.inten;
              end
            end
          end
        end
      end
      OP_WRITE: begin
        c.ev    = b.ev;
        c.prob  = b.prob;
        c.inten = b.inten;
        pattern_mem[store_index(b.slot, b.stepn)] = c;
      end
      OP_READ: begin
        c = pattern_mem[store_index(b.slot, b.stepn)];
        o.ev    = c.ev;
        o.inten = c.inten;
        o.prob  = c.prob;
      end
      default: begin
        have_last = 1'b0;
        last_idx  = 0;
      end
    endcase
    return o;
  endfunction

  function automatic void put_beat(op_e op, logic [POS_W-1:0] pos, logic [15:0] tempo,
                                   logic [SLOT_W-1:0] slot, logic [SNUM_W-1:0] stepn,
                                   logic [EV_W-1:0] ev, logic [PROB_W-1:0] prob,
                                   logic [INT_W-1:0] inten, bit known, outcome_t want);
    row_t r;
    r.is_reg = 1'b0;
    r.idx    = REG_ENABLED;
    r.val    = '0;
    r.beat   = '{op, pos, tempo, slot, stepn, ev, prob, inten};
    r.known  = known;
    r.want   = want;
    stim_table.push_back(r);
  endfunction

  function automatic void put_reg(reg_e idx, logic [CFG_W-1:0] val);
    row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.beat   = '0;
    r.known  = 1'b0;
    r.want   = '0;
    stim_table.push_back(r);
  endfunction

  // Random beat: mostly a host playing forward, with edits, reads and noise mixed in.
  function automatic beat_t rand_beat();
    beat_t       b;
    int unsigned pick;
    int unsigned len;
    b.pos   = 40'({$urandom, $urandom});
    b.tempo = 16'($urandom);
    b.slot  = SLOT_W'($urandom);
    b.stepn = SNUM_W'($urandom);
    b.ev    = EV_W'($urandom);
    b.prob  = PROB_W'($urandom);
    b.inten = INT_W'($urandom);
    len  = (int'(reg_length) > MAX_STEPS) ? MAX_STEPS : int'(reg_length);
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      b.op = OP_ADVANCE;
      if ($urandom_range(0, 9) != 0) begin
        play_pos += 40'($urandom_range(0, 32768));
        b.pos = play_pos;
      end
      case ($urandom_range(0, 19))
        0:       b.tempo = '0;
        1:       ;
        default: b.tempo = 16'($urandom_range(1, 300));
      endcase
    end else if (pick < 80) begin
      b.op = OP_WRITE;
      if ($urandom_range(0, 1) == 0) b.slot = reg_pattern;
      if (len != 0) b.stepn = SNUM_W'($urandom_range(0, len - 1));
      if ($urandom_range(0, 3) == 0) b.ev = '0;
      case ($urandom_range(0, 5))
        0:       b.prob = '0;
        1:       b.prob = 17'h0FFFF;
        2:       b.prob = 17'h10000;
        3:       b.prob = PROB_W'($urandom_range(65537, 131071));
        default: b.prob = PROB_W'($urandom_range(0, 65536));
      endcase
    end else if (pick < 92) begin
      b.op = OP_READ;
    end else begin
      b.op = OP_RESTART;
    end
    return b;
  endfunction

  function automatic void check_field(string what, logic [PROB_W-1:0] want,
                                      logic [PROB_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Offers one beat from the falling edge and holds it until it is taken.
  task automatic offer_beat(input beat_t b, input bit known, input outcome_t want);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cur_beat   = b;
    cur_known  = known;
    cur_want   = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering and waits until every awaited result has come back.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_ENABLED:    reg_enabled = val[0];
      REG_RESOLUTION: reg_res     = val[RES_W-1:0];
      REG_LENGTH:     reg_length  = val[LEN_W-1:0];
      REG_PATTERN:    reg_pattern = val[SLOT_W-1:0];
      REG_SEED:       rng         = (val == '0) ? SEED_W'(1) : val;
      default:        ;
    endcase
    reg_writes++;
  endtask

  // Monitor: predicts each accepted beat and checks each result taken.
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    outcome_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = step_outcome(cur_beat);
        if (cur_known) want = cur_want;
        outcomes_due.push_back(want);
        beat_count++;
        case (cur_beat.op)
          OP_WRITE:   write_count++;
          OP_READ:    read_count++;
          OP_RESTART: restart_count++;
          default:    ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        got.fired = triggered_o;
        got.ev    = event_code_o;
        got.inten = intensity_o;
        got.prob  = probability_o;
        if (outcomes_due.size() == 0) begin
          $display("%0t: result with none awaited, expected nothing, got %h", $time, got);
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          if (got.fired === 1'b1) fired_count++;
          check_field("triggered", PROB_W'(want.fired), PROB_W'(got.fired));
          check_field("event_code", PROB_W'(want.ev), PROB_W'(got.ev));
          check_field("intensity", PROB_W'(want.inten), PROB_W'(got.inten));
          check_field("probability", want.prob, got.prob);
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  initial begin : receiver
    int unsigned rx_tick;
    rx_tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      rx_tick++;
      case (rx_tick[9:8])
        2'd0: out_stall_i = 1'b0;
        2'd1: out_stall_i = ($urandom_range(0, 3) == 0);
        2'd2: out_stall_i = ($urandom_range(0, 9) < 6);
        default: out_stall_i = ((rx_tick % 7) < 3);
      endcase
    end
  end

  initial begin : watchdog
    #(64'd5_000_000);
    $display("%0t: run timed out with %0d results awaited", $time, outcomes_due.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int burst_left;
    int gap;
    int guard;
    int unsigned len;
    for (int i = 0; i < DEPTH; i++) pattern_mem[i] = '0;
    have_last   = 1'b0;
    last_idx    = 0;
    rng         = RESET_SEED;
    reg_enabled = 1'b0;
    reg_res     = RESET_RES;
    reg_length  = RESET_LEN;
    reg_pattern = '0;
    play_pos    = '0;

    // Directed table: reset state, store extremes, then the special cases of play.
    put_beat(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, QUIET);
    put_beat(OP_ADVANCE, 40'h12_3456_7890, 120, 0, 0, 0, 0, 0, 1, QUIET);
    put_beat(OP_WRITE, 0, 0, 7, 63, 4'hF, 17'h10000, 16'hFFFF, 1, QUIET);
    put_beat(OP_READ, 0, 0, 7, 63, 0, 0, 0, 1, '{1'b0, 4'hF, 16'hFFFF, 17'h10000});
    put_beat(OP_WRITE, 0, 0, 0, 0, 4'hF, 17'h1FFFF, 16'h1234, 1, QUIET);
    put_beat(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b0, 4'hF, 16'h1234, 17'h1FFFF});
    put_beat(OP_WRITE, 0, 0, 0, 1, 4'h1, 17'h00000, 16'hFFFF, 1, QUIET);
    put_beat(OP_WRITE, 0, 0, 0, 2, 4'h0, 17'h10000, 16'h5555, 1, QUIET);
    put_beat(OP_WRITE, 0, 0, 0, 3, 4'h8, 17'h08000, 16'hAAAA, 1, QUIET);
    put_reg(REG_ENABLED, 1);
    // Stopped transport gives nothing.
    put_beat(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, QUIET);
    put_beat(OP_ADVANCE, 0, 120, 0, 0, 0, 0, 0, 1, '{1'b1, 4'hF, 16'h1234, 17'h0});
    // The same step again stays quiet until a restart.
    put_beat(OP_ADVANCE, 0, 16'hFFFF, 0, 0, 0, 0, 0, 1, QUIET);
    put_beat(OP_RESTART, 40'hFF_FFFF_FFFF, 16'hFFFF, 7, 63, 4'hF, 17'h1FFFF, 16'hFFFF,
             1, QUIET);
    put_beat(OP_ADVANCE, 0, 1, 0, 0, 0, 0, 0, 1, '{1'b1, 4'hF, 16'h1234, 17'h0});
    put_beat(OP_ADVANCE, 40'h4000, 120, 0, 0, 0, 0, 0, 0, QUIET);
    put_beat(OP_ADVANCE, 40'h8000, 120, 0, 0, 0, 0, 0, 1, QUIET);
    put_beat(OP_ADVANCE, 40'hC000, 120, 0, 0, 0, 0, 0, 0, QUIET);
    put_beat(OP_ADVANCE, 40'hFF_FFFF_FFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0, QUIET);
    put_reg(REG_RESOLUTION, 3);
    put_reg(REG_LENGTH, 64);
    put_reg(REG_PATTERN, 7);
    put_reg(REG_SEED, 0);
    put_beat(OP_ADVANCE, 40'h7E000, 120, 0, 0, 0, 0, 0, 1, '{1'b1, 4'hF, 16'hFFFF, 17'h0});
    // An empty pattern never fires.
    put_reg(REG_LENGTH, 0);
    put_beat(OP_ADVANCE, 40'h1_0000, 120, 0, 0, 0, 0, 0, 1, QUIET);
    // Lengths beyond the store are clamped.
    put_reg(REG_LENGTH, 127);
    put_reg(REG_RESOLUTION, 0);
    put_beat(OP_ADVANCE, 40'(200) << 16, 60, 0, 0, 0, 0, 0, 0, QUIET);
    put_beat(OP_WRITE, 0, 0, 7, 8, 4'h3, 17'h0FFFF, 16'h0000, 1, QUIET);
    put_beat(OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 1, QUIET);
    put_beat(OP_ADVANCE, 40'(200) << 16, 60, 0, 0, 0, 0, 0, 0, QUIET);
    put_reg(REG_SEED, 32'hFFFF_FFFF);
    put_beat(OP_READ, 0, 0, 3, 5, 0, 0, 0, 1, QUIET);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The store is swept after reset; wait until the input opens.
    do @(posedge clk_i); while (in_stall_o);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_reg) begin
        settle_block();
        write_reg(stim_table[i].idx, stim_table[i].val);
      end else begin
        offer_beat(stim_table[i].beat, stim_table[i].known, stim_table[i].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      write_reg(REG_ENABLED, (ph == 6) ? 0 : 1);
      write_reg(REG_RESOLUTION, (ph < 4) ? ph : $urandom_range(0, 3));
      case (ph)
        0: len = 1;
        1: len = 64;
        3: len = 127;
        default:
          case ($urandom_range(0, 5))
            0:       len = $urandom_range(65, 127);
            1:       len = 0;
            default: len = $urandom_range(2, 40);
          endcase
      endcase
      write_reg(REG_LENGTH, len);
      write_reg(REG_PATTERN, $urandom_range(0, 7));
      if (ph % 3 == 0)
        write_reg(REG_SEED, (ph == 3) ? 32'hFFFF_FFFF : (ph == 9) ? 32'h0 : $urandom);
      play_pos = (ph == 4) ? 40'hFF_FFF0_0000 : 40'({$urandom, $urandom});
      burst_left = 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap = (ph % 4 == 1 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            @(negedge clk_i);
            in_valid_i = 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
        burst_left--;
        // Long output hold-off while beats keep coming, so the input backs up.
        if (ph == 2 && n == 20) hold_off_req = 1'b1;
        if ((ph == 5 && n == 60) || $urandom_range(0, 79) == 0) settle_block();
        offer_beat(rand_beat(), 1'b0, QUIET);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    guard = 0;
    while (outcomes_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (outcomes_due.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %h first", $time,
               outcomes_due.size(), outcomes_due[0]);
      mismatches += outcomes_due.size();
    end
    repeat (64) @(posedge clk_i);

    $display("Played %0d beats: %0d steps fired, %0d writes, %0d reads, %0d restarts.",
             beat_count, fired_count, write_count, read_count, restart_count);
    $display("Register writes %0d over %0d phases, one %0d-cycle output hold-off, %0d errors.",
             reg_writes, PHASES, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
